// ===== hdl/integer_matrix_multiply_unit_defines.svh =====
// Assertion macros for the integer matrix multiply unit.
// Needs nothing else; included by files that carry concurrent checks.
`ifndef INTEGER_MATRIX_MULTIPLY_UNIT_DEFINES_SVH
`define INTEGER_MATRIX_MULTIPLY_UNIT_DEFINES_SVH

`ifndef ASSERT_OFF
// clocked check with explicit clock and active-low reset
`define IMM_ASSERT_CLK(lbl, clk_s, rstn_s, prop) \
  lbl: assert property (@(posedge clk_s) disable iff (!rstn_s) prop) \
    else $error("imm assertion failed");
// clocked check on the default clk / rst_n pair
`define IMM_ASSERT(lbl, prop) `IMM_ASSERT_CLK(lbl, clk, rst_n, prop)
`else
`define IMM_ASSERT_CLK(lbl, clk_s, rstn_s, prop)
`define IMM_ASSERT(lbl, prop)
`endif

`endif

// ===== hdl/imm_pkg.sv =====
// Shared types and constants for the integer matrix multiply unit.
// No dependencies.
package imm_pkg;

  localparam int MAX_DIM = 8;
  localparam int DEPTH   = MAX_DIM * MAX_DIM;
  localparam int DATA_W  = 32;
  localparam int DIM_W   = 4;
  localparam int IDX_W   = 3;
  localparam int ADDR_W  = 6;
  localparam int CNT_W   = 7;
  localparam int CFG_W   = 2;

  localparam logic [CFG_W-1:0] REG_ROWS_A    = 2'd0;
  localparam logic [CFG_W-1:0] REG_INNER_DIM = 2'd1;
  localparam logic [CFG_W-1:0] REG_COLS_B    = 2'd2;

  localparam logic [DIM_W-1:0] DIM_RESET = 4'd8;
  localparam logic [DIM_W-1:0] DIM_MAX   = 4'd8;
  localparam logic [DIM_W-1:0] DIM_MIN   = 4'd1;

  typedef struct packed {
    logic [DIM_W-1:0] m;  // rows of A
    logic [DIM_W-1:0] n;  // inner dimension
    logic [DIM_W-1:0] p;  // columns of B
  } dims_t;

  typedef struct packed {
    logic              we_a;
    logic              we_b;
    logic [ADDR_W-1:0] addr;
  } ram_wr_t;

  typedef struct packed {
    logic valid;
    logic first;
    logic last;
  } mac_tag_t;

  function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] v);
    logic [DIM_W-1:0] r;
    r = v;
    if (v == '0) r = DIM_MIN;
    else if (v > DIM_MAX) r = DIM_MAX;
    return r;
  endfunction

endpackage

// ===== hdl/imm_if.sv =====
// Valid/ready channel interfaces of the integer matrix multiply unit.
// Uses imm_pkg for widths.
interface imm_in_if;
  logic                              valid;
  logic                              ready;
  logic signed [imm_pkg::DATA_W-1:0] element;

  modport source (output valid, output element, input ready);
  modport sink   (input valid, input element, output ready);
endinterface

interface imm_out_if;
  logic                              valid;
  logic                              ready;
  logic signed [imm_pkg::DATA_W-1:0] product;
  logic        [imm_pkg::IDX_W-1:0]  out_row;
  logic        [imm_pkg::IDX_W-1:0]  out_col;
  logic                              last;

  modport source (output valid, output product, output out_row, output out_col,
                  output last, input ready);
  modport sink   (input valid, input product, input out_row, input out_col,
                  input last, output ready);
endinterface

// ===== hdl/imm_ram.sv =====
// Matrix element store: one write port, one read port with registered data.
// Uses imm_pkg for depth and width.
module imm_ram (
  input  logic                              clk,
  input  logic                              we,
  input  logic [imm_pkg::ADDR_W-1:0]        waddr,
  input  logic [imm_pkg::DATA_W-1:0]        wdata,
  input  logic [imm_pkg::ADDR_W-1:0]        raddr,
  output logic [imm_pkg::DATA_W-1:0]        rdata
);

  logic [imm_pkg::DATA_W-1:0] mem [imm_pkg::DEPTH];
  logic [imm_pkg::DATA_W-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

// ===== hdl/imm_mac.sv =====
// Shared multiply-accumulate: registered product, then registered sum.
// Uses imm_pkg for the tag type and widths.
module imm_mac (
  input  logic                       clk,
  input  logic                       rst_n,
  input  imm_pkg::mac_tag_t          tag,
  input  logic [imm_pkg::DATA_W-1:0] a,
  input  logic [imm_pkg::DATA_W-1:0] b,
  output logic [imm_pkg::DATA_W-1:0] acc,
  output logic                       done
);

  logic [imm_pkg::DATA_W-1:0] prod_r;
  logic [imm_pkg::DATA_W-1:0] acc_r;
  imm_pkg::mac_tag_t          ptag_r;
  logic                       done_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ptag_r <= '0;
      done_r <= 1'b0;
    end else begin
      ptag_r <= tag;
      done_r <= ptag_r.valid && ptag_r.last;
    end
    prod_r <= a * b;  // low 32 bits only, wraps
    if (ptag_r.valid) begin
      acc_r <= ptag_r.first ? prod_r : acc_r + prod_r;
    end
  end

  assign acc  = acc_r;
  assign done = done_r;

endmodule

// ===== hdl/imm_seq.sv =====
// Sequencer: loads A and B, walks i/j/k over the shared MAC, holds the result.
// Uses imm_pkg, imm_in_if and imm_out_if.
module imm_seq (
  input  logic                        clk,
  input  logic                        rst_n,
  input  imm_pkg::dims_t              dims,
  input  logic                        restart,
  imm_in_if.sink                      in_req,
  imm_out_if.source                   out_res,
  output imm_pkg::ram_wr_t            ram_wr,
  output logic [imm_pkg::ADDR_W-1:0]  raddr_a,
  output logic [imm_pkg::ADDR_W-1:0]  raddr_b,
  output imm_pkg::mac_tag_t           tag,
  input  logic [imm_pkg::DATA_W-1:0]  mac_acc,
  input  logic                        mac_done
);

  typedef enum logic [1:0] {S_LOAD, S_ISSUE, S_DRAIN, S_EMIT} state_t;

  state_t                       state_r, state_nxt;
  logic                         loading_b_r, loading_b_nxt;
  logic [imm_pkg::CNT_W-1:0]    load_cnt_r, load_cnt_nxt;
  logic [imm_pkg::IDX_W-1:0]    i_r, i_nxt, j_r, j_nxt, k_r, k_nxt;
  logic [imm_pkg::ADDR_W-1:0]   a_base_r, a_base_nxt, b_ptr_r, b_ptr_nxt;
  imm_pkg::mac_tag_t            tag_r, tag_nxt;
  logic                         out_valid_r, out_valid_nxt;
  logic [imm_pkg::DATA_W-1:0]   product_r, product_nxt;
  logic [imm_pkg::IDX_W-1:0]    row_r, row_nxt, col_r, col_nxt;
  logic                         last_r, last_nxt;

  logic                         accept;
  logic [7:0]                   limit;
  logic [imm_pkg::CNT_W-1:0]    cnt_inc;
  logic [imm_pkg::DIM_W-1:0]    m_last, n_last, p_last;
  logic                         k_end, j_end, i_end;

  assign accept  = in_req.valid && (state_r == S_LOAD);
  assign limit   = loading_b_r ? ({4'd0, dims.n} * {4'd0, dims.p})
                               : ({4'd0, dims.m} * {4'd0, dims.n});
  assign cnt_inc = load_cnt_r + 1'b1;
  assign m_last  = dims.m - 1'b1;
  assign n_last  = dims.n - 1'b1;
  assign p_last  = dims.p - 1'b1;
  assign k_end   = ({1'b0, k_r} == n_last);
  assign j_end   = ({1'b0, j_r} == p_last);
  assign i_end   = ({1'b0, i_r} == m_last);

  always_comb begin
    state_nxt     = state_r;
    loading_b_nxt = loading_b_r;
    load_cnt_nxt  = load_cnt_r;
    i_nxt         = i_r;
    j_nxt         = j_r;
    k_nxt         = k_r;
    a_base_nxt    = a_base_r;
    b_ptr_nxt     = b_ptr_r;
    tag_nxt       = '0;
    out_valid_nxt = out_valid_r;
    product_nxt   = product_r;
    row_nxt       = row_r;
    col_nxt       = col_r;
    last_nxt      = last_r;

    case (state_r)
      S_LOAD: begin
        if (accept) begin
          if ({1'b0, cnt_inc} == limit) begin
            load_cnt_nxt = '0;
            if (!loading_b_r) begin
              loading_b_nxt = 1'b1;
            end else begin
              loading_b_nxt = 1'b0;
              state_nxt     = S_ISSUE;
              i_nxt         = '0;
              j_nxt         = '0;
              k_nxt         = '0;
              a_base_nxt    = '0;
              b_ptr_nxt     = '0;
            end
          end else begin
            load_cnt_nxt = cnt_inc;
          end
        end
      end
      S_ISSUE: begin
        tag_nxt.valid = 1'b1;
        tag_nxt.first = (k_r == '0);
        tag_nxt.last  = k_end;
        if (k_end) begin
          k_nxt     = '0;
          state_nxt = S_DRAIN;
        end else begin
          k_nxt     = k_r + 1'b1;
          b_ptr_nxt = b_ptr_r + {2'b00, dims.p};
        end
      end
      S_DRAIN: begin
        if (mac_done) begin
          product_nxt   = mac_acc;
          row_nxt       = i_r;
          col_nxt       = j_r;
          last_nxt      = i_end && j_end;
          out_valid_nxt = 1'b1;
          state_nxt     = S_EMIT;
        end
      end
      S_EMIT: begin
        if (out_res.ready) begin
          out_valid_nxt = 1'b0;
          if (last_r) begin
            state_nxt = S_LOAD;
          end else begin
            state_nxt = S_ISSUE;
            if (j_end) begin
              j_nxt      = '0;
              i_nxt      = i_r + 1'b1;
              a_base_nxt = a_base_r + {2'b00, dims.n};
            end else begin
              j_nxt = j_r + 1'b1;
            end
            b_ptr_nxt = {3'b000, j_nxt};
          end
        end
      end
      default: begin
        state_nxt = S_LOAD;
      end
    endcase

    // register write restarts loading
    if (restart) begin
      load_cnt_nxt  = '0;
      loading_b_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_LOAD;
      loading_b_r <= 1'b0;
      load_cnt_r  <= '0;
      tag_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      loading_b_r <= loading_b_nxt;
      load_cnt_r  <= load_cnt_nxt;
      tag_r       <= tag_nxt;
      out_valid_r <= out_valid_nxt;
    end
    i_r       <= i_nxt;
    j_r       <= j_nxt;
    k_r       <= k_nxt;
    a_base_r  <= a_base_nxt;
    b_ptr_r   <= b_ptr_nxt;
    product_r <= product_nxt;
    row_r     <= row_nxt;
    col_r     <= col_nxt;
    last_r    <= last_nxt;
  end

  assign in_req.ready    = (state_r == S_LOAD);
  assign ram_wr.we_a     = accept && !loading_b_r;
  assign ram_wr.we_b     = accept && loading_b_r;
  assign ram_wr.addr     = load_cnt_r[imm_pkg::ADDR_W-1:0];
  assign raddr_a         = a_base_r + {3'b000, k_r};
  assign raddr_b         = b_ptr_r;
  assign tag             = tag_r;

  assign out_res.valid   = out_valid_r;
  assign out_res.product = product_r;
  assign out_res.out_row = row_r;
  assign out_res.out_col = col_r;
  assign out_res.last    = last_r;

endmodule

// ===== hdl/integer_matrix_multiply_unit.sv =====
// Top level of the integer matrix multiply unit: config registers, stores,
// shared MAC and sequencer. Uses imm_pkg, imm_if, imm_ram, imm_mac, imm_seq.
//
//  channel   dir  handshake          payload
//  in_req    in   valid/ready        element (s32): A then B, row-major
//  out_res   out  valid/ready        product (s32), out_row, out_col, last
//  cfg_*     in   cfg_we, no ready   cfg_idx (0 rows_a, 1 inner_dim, 2 cols_b)
//
// Loading takes one element per cycle while in_req.ready is high.
// The element that completes B starts the compute; each C element then goes
// through n MAC issues, multiply, add, result capture and hand-off, plus any
// out_res stall; in_req.ready stays low until the last C element is taken.
// Synchronous active-low reset: dims return to 8, loading restarts with A.
// Store contents are not reset; every entry read was written this pass.
`include "integer_matrix_multiply_unit_defines.svh"

module integer_matrix_multiply_unit (
  input  logic                       clk,
  input  logic                       rst_n,
  imm_in_if.sink                     in_req,
  imm_out_if.source                  out_res,
  input  logic                       cfg_we,
  input  logic [imm_pkg::CFG_W-1:0]  cfg_idx,
  input  logic [imm_pkg::DIM_W-1:0]  cfg_data
);

  // raw register values; clamped before use
  logic [imm_pkg::DIM_W-1:0] rows_a_r, inner_dim_r, cols_b_r;
  logic                      restart;
  imm_pkg::dims_t            dims;

  imm_pkg::ram_wr_t          ram_wr;
  logic [imm_pkg::ADDR_W-1:0] raddr_a, raddr_b;
  logic [imm_pkg::DATA_W-1:0] rdata_a, rdata_b;
  imm_pkg::mac_tag_t         tag;
  logic [imm_pkg::DATA_W-1:0] mac_acc;
  logic                      mac_done;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rows_a_r    <= imm_pkg::DIM_RESET;
      inner_dim_r <= imm_pkg::DIM_RESET;
      cols_b_r    <= imm_pkg::DIM_RESET;
    end else if (cfg_we) begin
      case (cfg_idx)
        imm_pkg::REG_ROWS_A:    rows_a_r    <= cfg_data;
        imm_pkg::REG_INNER_DIM: inner_dim_r <= cfg_data;
        imm_pkg::REG_COLS_B:    cols_b_r    <= cfg_data;
        default: begin
          // unmapped index: ignored
        end
      endcase
    end
  end

  // any write to a mapped register restarts loading at A
  assign restart = cfg_we && (cfg_idx == imm_pkg::REG_ROWS_A ||
                              cfg_idx == imm_pkg::REG_INNER_DIM ||
                              cfg_idx == imm_pkg::REG_COLS_B);

  assign dims.m = imm_pkg::clamp_dim(rows_a_r);
  assign dims.n = imm_pkg::clamp_dim(inner_dim_r);
  assign dims.p = imm_pkg::clamp_dim(cols_b_r);

  imm_ram u_store_a (
    .clk   (clk),
    .we    (ram_wr.we_a),
    .waddr (ram_wr.addr),
    .wdata (in_req.element),
    .raddr (raddr_a),
    .rdata (rdata_a)
  );

  imm_ram u_store_b (
    .clk   (clk),
    .we    (ram_wr.we_b),
    .waddr (ram_wr.addr),
    .wdata (in_req.element),
    .raddr (raddr_b),
    .rdata (rdata_b)
  );

  imm_mac u_mac (
    .clk   (clk),
    .rst_n (rst_n),
    .tag   (tag),
    .a     (rdata_a),
    .b     (rdata_b),
    .acc   (mac_acc),
    .done  (mac_done)
  );

  imm_seq u_seq (
    .clk      (clk),
    .rst_n    (rst_n),
    .dims     (dims),
    .restart  (restart),
    .in_req   (in_req),
    .out_res  (out_res),
    .ram_wr   (ram_wr),
    .raddr_a  (raddr_a),
    .raddr_b  (raddr_b),
    .tag      (tag),
    .mac_acc  (mac_acc),
    .mac_done (mac_done)
  );

  // loading and result delivery never overlap
  `IMM_ASSERT(a_no_load_while_emit, !(in_req.ready && out_res.valid))
  // taking the final result reopens loading
  `IMM_ASSERT(a_last_reopens, out_res.valid && out_res.ready && out_res.last |=> in_req.ready)
  // a request taken cannot produce a result in the very next cycle
  `IMM_ASSERT(a_no_instant_result, in_req.valid && in_req.ready |=> !out_res.valid)

endmodule

// ===== tb/imm_result_checker.sv =====
// Result checker for the integer matrix multiply unit: watches both channels
// and the config port, predicts every C element and compares. Uses imm_pkg, imm_if.
module imm_result_checker (
  input  logic                      clk,
  input  logic                      rst_n,
  imm_in_if                         in_ch,
  imm_out_if                        out_ch,
  input  logic                      cfg_we,
  input  logic [imm_pkg::CFG_W-1:0] cfg_idx,
  input  logic [imm_pkg::DIM_W-1:0] cfg_data,
  output int                        mismatches,
  output int                        pending
);
  import imm_pkg::*;

  typedef struct {
    logic [DATA_W-1:0] product;
    logic [IDX_W-1:0]  row;
    logic [IDX_W-1:0]  col;
    logic              last;
  } c_elem_t;

  c_elem_t           c_expected_q[$];
  logic [DIM_W-1:0]  rows_raw, inner_raw, cols_raw;
  logic [DATA_W-1:0] a_mat[DEPTH];
  logic [DATA_W-1:0] b_mat[DEPTH];
  int unsigned       load_cnt;
  logic              loading_b;

  // 0 acts as 1, anything past MAX_DIM as MAX_DIM
  function automatic int unsigned shape_dim(input logic [DIM_W-1:0] v);
    if (v == '0) return 1;
    if (v > MAX_DIM) return MAX_DIM;
    return 32'(v);
  endfunction

  task automatic check_field(input string name, input logic [DATA_W-1:0] want,
                             input logic [DATA_W-1:0] got);
    if (got !== want) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
      mismatches++;
    end
  endtask

  always @(posedge clk) begin : predict
    c_elem_t           want;
    int unsigned       m, n, p, i, j, k;
    logic [DATA_W-1:0] acc;
    if (!rst_n) begin
      rows_raw  = DIM_RESET;
      inner_raw = DIM_RESET;
      cols_raw  = DIM_RESET;
      load_cnt  = 0;
      loading_b = 1'b0;
      c_expected_q.delete();
    end else begin
      if (out_ch.valid === 1'b1 && out_ch.ready === 1'b1) begin
        if (c_expected_q.size() == 0) begin
          $error("unexpected result: row %0d col %0d product 0x%0h",
                 out_ch.out_row, out_ch.out_col, out_ch.product);
          mismatches++;
        end else begin
          want = c_expected_q.pop_front();
          check_field("product", want.product, out_ch.product);
          check_field("out_row", DATA_W'(want.row), DATA_W'(out_ch.out_row));
          check_field("out_col", DATA_W'(want.col), DATA_W'(out_ch.out_col));
          check_field("last", DATA_W'(want.last), DATA_W'(out_ch.last));
        end
      end

      // any write to a real register restarts loading with A
      if (cfg_we === 1'b1) begin
        case (cfg_idx)
          REG_ROWS_A: begin
            rows_raw  = cfg_data;
            load_cnt  = 0;
            loading_b = 1'b0;
          end
          REG_INNER_DIM: begin
            inner_raw = cfg_data;
            load_cnt  = 0;
            loading_b = 1'b0;
          end
          REG_COLS_B: begin
            cols_raw  = cfg_data;
            load_cnt  = 0;
            loading_b = 1'b0;
          end
          default: ;
        endcase
      end

      if (in_ch.valid === 1'b1 && in_ch.ready === 1'b1) begin
        m = shape_dim(rows_raw);
        n = shape_dim(inner_raw);
        p = shape_dim(cols_raw);
        if (!loading_b) begin
          a_mat[load_cnt % DEPTH] = in_ch.element;
          load_cnt++;
          if (load_cnt >= m * n) begin
            load_cnt  = 0;
            loading_b = 1'b1;
          end
        end else begin
          b_mat[load_cnt % DEPTH] = in_ch.element;
          load_cnt++;
          if (load_cnt >= n * p) begin
            load_cnt  = 0;
            loading_b = 1'b0;
            // B complete: queue all of C, row-major
            for (i = 0; i < m; i++) begin
              for (j = 0; j < p; j++) begin
                acc = '0;
                for (k = 0; k < n; k++)
                  acc = acc + a_mat[(i * n + k) % DEPTH] * b_mat[(k * p + j) % DEPTH];
                want.product = acc;
                want.row     = i[IDX_W-1:0];
                want.col     = j[IDX_W-1:0];
                want.last    = (i == m - 1) && (j == p - 1);
                c_expected_q.push_back(want);
              end
            end
          end
        end
      end
    end
    pending = c_expected_q.size();
  end

endmodule

// ===== tb/tb_integer_matrix_multiply_unit.sv =====
// Testbench top for the integer matrix multiply unit: clock, reset, request
// stimulus, result back-pressure and verdict. Uses imm_pkg, imm_if, imm_result_checker.
module tb_integer_matrix_multiply_unit;
  import imm_pkg::*;

  // index past the register list: the block must ignore it
  localparam logic [CFG_W-1:0] REG_NONE = 2'd3;

  localparam int SETTLE       = 16;      // exceeds the time one C element takes
  localparam int RANDOM_ITEMS = 270;
  localparam int CYCLE_LIMIT  = 400000;

  logic             clk = 1'b0;
  logic             rst_n;
  logic             cfg_we;
  logic [CFG_W-1:0] cfg_idx;
  logic [DIM_W-1:0] cfg_data;

  int mismatches;
  int pending;
  int cycles;
  int burst_left;
  int sent;

  imm_in_if  in_req();
  imm_out_if out_res();

  integer_matrix_multiply_unit dut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_req  (in_req),
    .out_res (out_res),
    .cfg_we  (cfg_we),
    .cfg_idx (cfg_idx),
    .cfg_data(cfg_data)
  );

  imm_result_checker chk (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_req),
    .out_ch    (out_res),
    .cfg_we    (cfg_we),
    .cfg_idx   (cfg_idx),
    .cfg_data  (cfg_data),
    .mismatches(mismatches),
    .pending   (pending)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // hard stop in case the block hangs
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("tb_integer_matrix_multiply_unit: errors");
      $finish;
    end
  end

  // Result side: ready follows its own pattern, independent of the sender.
  // Modes: always ready, coin flip per cycle, or ready one cycle in every few.
  initial begin : result_backpressure
    int mode, span, period, tick;
    out_res.ready = 1'b0;
    tick = 0;
    forever begin
      mode   = $urandom_range(0, 2);
      span   = $urandom_range(8, 48);
      period = $urandom_range(2, 4);
      repeat (span) begin
        @(negedge clk);
        tick++;
        case (mode)
          0:       out_res.ready <= 1'b1;
          1:       out_res.ready <= 1'($urandom_range(0, 1));
          default: out_res.ready <= (tick % period) == 0;
        endcase
      end
    end
  end

  function automatic int dim_eff(input logic [DIM_W-1:0] v);
    if (v == '0) return 1;
    if (v > MAX_DIM) return MAX_DIM;
    return int'(v);
  endfunction

  // raw register value: mostly small shapes, sometimes 0 or 8 to 15
  function automatic logic [DIM_W-1:0] rand_dim();
    case ($urandom_range(0, 11))
      0:       return '0;
      1:       return DIM_W'($urandom_range(8, 15));
      default: return DIM_W'($urandom_range(1, 4));
    endcase
  endfunction

  function automatic logic [DATA_W-1:0] rand_element();
    int small_val;
    small_val = $urandom_range(0, 16);
    case ($urandom_range(0, 7))
      0: begin
        case ($urandom_range(0, 4))
          0:       return 32'h8000_0000;
          1:       return 32'h7fff_ffff;
          2:       return 32'hffff_ffff;
          3:       return 32'h0000_0001;
          default: return '0;
        endcase
      end
      1:       return small_val - 8;
      default: return $urandom;
    endcase
  endfunction

  // register write; cfg_we is lowered again before the task returns, so writes never run back to back
  task automatic write_reg(input logic [CFG_W-1:0] idx, input logic [DIM_W-1:0] val);
    cfg_we   <= 1'b1;
    cfg_idx  <= idx;
    cfg_data <= val;
    @(negedge clk);
    cfg_we   <= 1'b0;
    @(negedge clk);
  endtask

  // One element request. Sender runs in bursts; a gap opens only between
  // bursts, and valid is only lowered when that gap is not empty.
  task automatic push_element(input logic [DATA_W-1:0] v);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        in_req.valid <= 1'b0;
        repeat (gap) @(negedge clk);
      end
      burst_left = $urandom_range(1, 16);
    end
    burst_left--;
    in_req.valid   <= 1'b1;
    in_req.element <= v;
    @(posedge clk);
    while (in_req.ready !== 1'b1) @(posedge clk);
    sent++;
    @(negedge clk);
  endtask

  task automatic load_matrices(input int count);
    repeat (count) push_element(rand_element());
  endtask

  // Sender holds off until all of C is back, then lets the pipeline drain.
  task automatic settle();
    in_req.valid <= 1'b0;
    do @(negedge clk); while (pending != 0);
    repeat (SETTLE) @(negedge clk);
  endtask

  initial begin : stimulus
    logic [DATA_W-1:0] row_by_col[9];
    logic [DIM_W-1:0]  cur_rows, cur_inner, cur_cols;
    int                phase, total;
    logic              broken;

    rst_n          = 1'b0;
    cfg_we         = 1'b0;
    cfg_idx        = REG_ROWS_A;
    cfg_data       = '0;
    in_req.valid   = 1'b0;
    in_req.element = '0;
    burst_left     = 0;
    sent           = 0;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // 1 x 1 times 1 x 8: zero register acts as 1, 15 acts as 8.
    // Extremes: min*min wraps to 0, max, -1, all-ones/alternating bits.
    write_reg(REG_ROWS_A, 4'd0);
    write_reg(REG_INNER_DIM, 4'd0);
    write_reg(REG_COLS_B, 4'd15);
    row_by_col = '{32'h8000_0000, 32'h8000_0000, 32'h7fff_ffff, 32'hffff_ffff,
                   32'h0000_0000, 32'h0000_0001, 32'h7fff_ffff, 32'h5555_5555,
                   32'haaaa_aaaa};
    foreach (row_by_col[e]) push_element(row_by_col[e]);
    settle();

    // 1x1x1: A loaded, then a write past the register list must not restart
    write_reg(REG_ROWS_A, 4'd1);
    write_reg(REG_INNER_DIM, 4'd1);
    write_reg(REG_COLS_B, 4'd1);
    push_element(32'h7fff_ffff);
    settle();
    write_reg(REG_NONE, 4'd5);
    push_element(32'h7fff_ffff);
    settle();

    // A loaded but B not, then a real write restarts loading with the new shape
    push_element(32'd5);
    settle();
    write_reg(REG_ROWS_A, 4'd2);
    push_element(32'hffff_ffff);
    push_element(32'h8000_0000);
    push_element(32'hffff_ffff);
    settle();

    // 2x2x2 with random content, sums wrap
    write_reg(REG_INNER_DIM, 4'd2);
    write_reg(REG_COLS_B, 4'd2);
    load_matrices(8);
    cur_rows  = 4'd2;
    cur_inner = 4'd2;
    cur_cols  = 4'd2;

    // Random phases: mostly whole A/B pairs; now and then a pair cut short,
    // which the next phase's register write must discard.
    phase  = 0;
    broken = 1'b0;
    while (sent < RANDOM_ITEMS) begin
      settle();
      if (phase == 0) begin
        // full 8x8x8 once, reaching row and column 7
        cur_rows  = 4'd8;
        cur_inner = 4'd12;
        cur_cols  = 4'd15;
        write_reg(REG_ROWS_A, cur_rows);
        write_reg(REG_INNER_DIM, cur_inner);
        write_reg(REG_COLS_B, cur_cols);
      end else begin
        if (broken || $urandom_range(0, 2) != 0) begin
          cur_rows = rand_dim();
          write_reg(REG_ROWS_A, cur_rows);
        end
        if ($urandom_range(0, 2) != 0) begin
          cur_inner = rand_dim();
          write_reg(REG_INNER_DIM, cur_inner);
        end
        if ($urandom_range(0, 2) != 0) begin
          cur_cols = rand_dim();
          write_reg(REG_COLS_B, cur_cols);
        end
        if ($urandom_range(0, 7) == 0)
          write_reg(REG_NONE, DIM_W'($urandom_range(0, 15)));
      end
      total  = dim_eff(cur_rows) * dim_eff(cur_inner)
             + dim_eff(cur_inner) * dim_eff(cur_cols);
      broken = (phase != 0) && ($urandom_range(0, 7) == 0);
      load_matrices(broken ? $urandom_range(1, total - 1) : total);
      phase++;
    end

    // drain: all of C back, then SETTLE quiet cycles
    settle();
    if (mismatches == 0)
      $display("tb_integer_matrix_multiply_unit: clean");
    else
      $display("tb_integer_matrix_multiply_unit: errors");
    $finish;
  end

endmodule
